@@ rtl/sts_pkg.sv @@
// Shared types and constants of the two-axis stepped servo tracker.
package sts_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_AIM_X      = 3'd0,
    CFG_AIM_Y      = 3'd1,
    CFG_DEADZONE   = 3'd2,
    CFG_THR_SMALL  = 3'd3,
    CFG_THR_MEDIUM = 3'd4,
    CFG_DUTY_MIN   = 3'd5,
    CFG_DUTY_MAX   = 3'd6,
    CFG_DUTY_CTR   = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 3;

  // Input command codes.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POINT = 1'b1
  } cmd_e;

  // Fixed field widths.
  localparam int unsigned DeadzoneWidth = 8;
  localparam int unsigned ThrWidth      = 9;
  localparam int unsigned StepWidth     = 3;

  // Duty step sizes.
  localparam logic [StepWidth-1:0] StepSmall  = 3'd1;
  localparam logic [StepWidth-1:0] StepMedium = 3'd3;
  localparam logic [StepWidth-1:0] StepLarge  = 3'd5;

  // Register reset values.
  localparam int unsigned AimXRst      = 160;
  localparam int unsigned AimYRst      = 100;
  localparam int unsigned DeadzoneRst  = 3;
  localparam int unsigned ThrSmallRst  = 10;
  localparam int unsigned ThrMediumRst = 30;
  localparam int unsigned DutyMinRst   = 500;
  localparam int unsigned DutyMaxRst   = 2500;
  localparam int unsigned DutyCtrRst   = 1500;

endpackage

@@ rtl/sts_if.sv @@
// Valid/ready channel interfaces for the tracker's input and result items.
interface sts_in_if #(
  parameter int unsigned COORD_WIDTH = 9
);
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [COORD_WIDTH-1:0] point_x;
  logic [COORD_WIDTH-1:0] point_y;

  modport source (output valid, command, point_x, point_y, input ready);
  modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

interface sts_out_if #(
  parameter int unsigned DUTY_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [DUTY_WIDTH-1:0] duty_x;
  logic [DUTY_WIDTH-1:0] duty_y;
  logic                  running;
  logic                  on_target;
  logic                  moved;

  modport source (output valid, duty_x, duty_y, running, on_target, moved, input ready);
  modport sink   (input valid, duty_x, duty_y, running, on_target, moved, output ready);
endinterface

@@ rtl/sts_cfg_regs.sv @@
// Configuration register file of the tracker.
module sts_cfg_regs #(
  parameter int unsigned COORD_WIDTH = 9,
  parameter int unsigned DUTY_WIDTH  = 16,
  parameter int unsigned CFG_WIDTH   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sts_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]              cfg_data_i,
  output logic [COORD_WIDTH-1:0]            aim_x_o,
  output logic [COORD_WIDTH-1:0]            aim_y_o,
  output logic [sts_pkg::DeadzoneWidth-1:0] deadzone_o,
  output logic [sts_pkg::ThrWidth-1:0]      thr_small_o,
  output logic [sts_pkg::ThrWidth-1:0]      thr_medium_o,
  output logic [DUTY_WIDTH-1:0]             duty_min_o,
  output logic [DUTY_WIDTH-1:0]             duty_max_o
);
  import sts_pkg::*;

  logic [COORD_WIDTH-1:0]   aim_x_q, aim_y_q;
  logic [DeadzoneWidth-1:0] deadzone_q;
  logic [ThrWidth-1:0]      thr_small_q, thr_medium_q;
  logic [DUTY_WIDTH-1:0]    duty_min_q, duty_max_q;

  // The center duty only sets the reset value of the servo duties, which
  // comes from its own reset constant, so a write to it stores nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aim_x_q      <= COORD_WIDTH'(AimXRst);
      aim_y_q      <= COORD_WIDTH'(AimYRst);
      deadzone_q   <= DeadzoneWidth'(DeadzoneRst);
      thr_small_q  <= ThrWidth'(ThrSmallRst);
      thr_medium_q <= ThrWidth'(ThrMediumRst);
      duty_min_q   <= DUTY_WIDTH'(DutyMinRst);
      duty_max_q   <= DUTY_WIDTH'(DutyMaxRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AIM_X:      aim_x_q      <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_AIM_Y:      aim_y_q      <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_DEADZONE:   deadzone_q   <= cfg_data_i[DeadzoneWidth-1:0];
        CFG_THR_SMALL:  thr_small_q  <= cfg_data_i[ThrWidth-1:0];
        CFG_THR_MEDIUM: thr_medium_q <= cfg_data_i[ThrWidth-1:0];
        CFG_DUTY_MIN:   duty_min_q   <= cfg_data_i[DUTY_WIDTH-1:0];
        CFG_DUTY_MAX:   duty_max_q   <= cfg_data_i[DUTY_WIDTH-1:0];
        CFG_DUTY_CTR:   ;
        default:        ;
      endcase
    end
  end

  assign aim_x_o      = aim_x_q;
  assign aim_y_o      = aim_y_q;
  assign deadzone_o   = deadzone_q;
  assign thr_small_o  = thr_small_q;
  assign thr_medium_o = thr_medium_q;
  assign duty_min_o   = duty_min_q;
  assign duty_max_o   = duty_max_q;

endmodule

@@ rtl/sts_axis.sv @@
// One axis of the tracker: error, deadzone test, step choice and duty clamp.
module sts_axis #(
  parameter int unsigned COORD_WIDTH = 9,
  parameter int unsigned DUTY_WIDTH  = 16,
  parameter bit          INVERT      = 1'b0
) (
  input  logic [COORD_WIDTH-1:0]            point_i,
  input  logic [COORD_WIDTH-1:0]            aim_i,
  input  logic [sts_pkg::DeadzoneWidth-1:0] deadzone_i,
  input  logic [sts_pkg::ThrWidth-1:0]      thr_small_i,
  input  logic [sts_pkg::ThrWidth-1:0]      thr_medium_i,
  input  logic [DUTY_WIDTH-1:0]             duty_i,
  input  logic [DUTY_WIDTH-1:0]             duty_min_i,
  input  logic [DUTY_WIDTH-1:0]             duty_max_i,
  output logic                              in_dead_o,
  output logic [DUTY_WIDTH-1:0]             duty_o
);
  import sts_pkg::*;

  // Compare width holds the magnitude and both limits, with one spare bit.
  localparam int unsigned CmpWidth =
      ((COORD_WIDTH > ThrWidth) ? COORD_WIDTH : ThrWidth) + 1;
  localparam int unsigned SumWidth = DUTY_WIDTH + 2;

  logic signed [COORD_WIDTH:0]   err;
  logic signed [COORD_WIDTH:0]   err_abs;
  logic [CmpWidth-1:0]           mag;
  logic [StepWidth-1:0]          step;
  logic signed [SumWidth-1:0]    sum;
  logic signed [SumWidth-1:0]    lim_max;
  logic signed [SumWidth-1:0]    lim_min;
  logic signed [SumWidth-1:0]    step_s;
  logic signed [SumWidth-1:0]    clamped;
  logic                          step_up;

  always_comb begin
    err     = $signed({1'b0, point_i}) - $signed({1'b0, aim_i});
    err_abs = err[COORD_WIDTH] ? -err : err;
    mag     = {{(CmpWidth-COORD_WIDTH){1'b0}}, err_abs[COORD_WIDTH-1:0]};

    in_dead_o = mag < {{(CmpWidth-DeadzoneWidth){1'b0}}, deadzone_i};

    if (mag < {{(CmpWidth-ThrWidth){1'b0}}, thr_small_i}) begin
      step = StepSmall;
    end else if (mag < {{(CmpWidth-ThrWidth){1'b0}}, thr_medium_i}) begin
      step = StepMedium;
    end else begin
      step = StepLarge;
    end

    // A positive error raises the duty unless the axis is inverted.
    step_up = err[COORD_WIDTH] ? INVERT : !INVERT;
    step_s  = $signed({{(SumWidth-StepWidth){1'b0}}, step});
    sum     = $signed({2'b00, duty_i});
    if (err != '0) begin
      sum = step_up ? (sum + step_s) : (sum - step_s);
    end

    // Saturate to the maximum first, then to the minimum.
    lim_max = $signed({2'b00, duty_max_i});
    lim_min = $signed({2'b00, duty_min_i});
    clamped = sum;
    if (clamped > lim_max) begin
      clamped = lim_max;
    end
    if (clamped < lim_min) begin
      clamped = lim_min;
    end
    duty_o = clamped[DUTY_WIDTH-1:0];
  end

endmodule

@@ rtl/two_axis_stepped_servo_tracker.sv @@
// Top level of the two-axis stepped servo tracker.
//
// The tracker steers a pan/tilt pair of servos toward an aim point. A start
// item switches tracking on; a measurement item carries a spot coordinate
// that, while tracking and not at (0,0), is compared with the aim point on
// both axes. When both absolute errors fall below the deadzone the item
// reports on_target and tracking stops; otherwise each duty steps by 1, 3 or
// 5 depending on the error size (X against its error, Y with it) and is
// clamped to the configured duty range. Every item produces exactly one
// result item. The block takes one item per cycle while its results are
// taken. An item waits in the input register, and the step logic then
// writes the servo state and the result register from it once the result
// register can take a new item. The next item always sees the state the
// previous one left.
// Both registers stall together when the result is not taken, and an item is
// still accepted while a finished result waits, as long as the input register
// is free. The user writes configuration through a plain write port while
// the block is idle; the block itself does not enforce this. Writing the
// center duty stores nothing; both duties reset to the center reset value.
module two_axis_stepped_servo_tracker #(
  parameter int unsigned COORD_WIDTH = 9,
  parameter int unsigned DUTY_WIDTH  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sts_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [((DUTY_WIDTH > COORD_WIDTH) ?
                 ((DUTY_WIDTH > sts_pkg::ThrWidth) ? DUTY_WIDTH : sts_pkg::ThrWidth) :
                 ((COORD_WIDTH > sts_pkg::ThrWidth) ? COORD_WIDTH : sts_pkg::ThrWidth))-1:0]
                                          cfg_data_i,
  sts_in_if.sink                          in_i,
  sts_out_if.source                       out_o
);
  import sts_pkg::*;

  localparam int unsigned CfgWidth = (DUTY_WIDTH > COORD_WIDTH) ?
      ((DUTY_WIDTH > ThrWidth) ? DUTY_WIDTH : ThrWidth) :
      ((COORD_WIDTH > ThrWidth) ? COORD_WIDTH : ThrWidth);

  // Configuration registers.
  logic [COORD_WIDTH-1:0]   aim_x, aim_y;
  logic [DeadzoneWidth-1:0] deadzone;
  logic [ThrWidth-1:0]      thr_small, thr_medium;
  logic [DUTY_WIDTH-1:0]    duty_min, duty_max;

  sts_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .DUTY_WIDTH  (DUTY_WIDTH),
    .CFG_WIDTH   (CfgWidth)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .aim_x_o      (aim_x),
    .aim_y_o      (aim_y),
    .deadzone_o   (deadzone),
    .thr_small_o  (thr_small),
    .thr_medium_o (thr_medium),
    .duty_min_o   (duty_min),
    .duty_max_o   (duty_max)
  );

  // Input register.
  logic                   s1_valid_q;
  logic                   s1_cmd_q;
  logic [COORD_WIDTH-1:0] s1_px_q, s1_py_q;

  // Result register and servo state.
  logic                  out_valid_q;
  logic [DUTY_WIDTH-1:0] out_dx_q, out_dy_q;
  logic                  out_run_q, out_ont_q, out_mov_q;
  logic                  track_q, track_d;
  logic [DUTY_WIDTH-1:0] duty_x_q, duty_x_d, duty_y_q, duty_y_d;
  logic                  on_target_d, moved_d;

  logic advance;
  logic in_fire;

  // The result register can take a new item when empty or being drained.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= in_i.command;
      s1_px_q  <= in_i.point_x;
      s1_py_q  <= in_i.point_y;
    end
  end

  // Per-axis step logic; X is inverted so it moves against its error.
  logic                  dead_x, dead_y;
  logic [DUTY_WIDTH-1:0] step_x, step_y;

  sts_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .DUTY_WIDTH  (DUTY_WIDTH),
    .INVERT      (1'b1)
  ) u_axis_x (
    .point_i      (s1_px_q),
    .aim_i        (aim_x),
    .deadzone_i   (deadzone),
    .thr_small_i  (thr_small),
    .thr_medium_i (thr_medium),
    .duty_i       (duty_x_q),
    .duty_min_i   (duty_min),
    .duty_max_i   (duty_max),
    .in_dead_o    (dead_x),
    .duty_o       (step_x)
  );

  sts_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .DUTY_WIDTH  (DUTY_WIDTH),
    .INVERT      (1'b0)
  ) u_axis_y (
    .point_i      (s1_py_q),
    .aim_i        (aim_y),
    .deadzone_i   (deadzone),
    .thr_small_i  (thr_small),
    .thr_medium_i (thr_medium),
    .duty_i       (duty_y_q),
    .duty_min_i   (duty_min),
    .duty_max_i   (duty_max),
    .in_dead_o    (dead_y),
    .duty_o       (step_y)
  );

  // Next state for the item in the input register.
  always_comb begin
    track_d     = track_q;
    duty_x_d    = duty_x_q;
    duty_y_d    = duty_y_q;
    on_target_d = 1'b0;
    moved_d     = 1'b0;
    if (cmd_e'(s1_cmd_q) == CMD_START) begin
      track_d = 1'b1;
    end else if (track_q && (s1_px_q != '0 || s1_py_q != '0)) begin
      if (dead_x && dead_y) begin
        on_target_d = 1'b1;
        track_d     = 1'b0;
      end else begin
        duty_x_d = step_x;
        duty_y_d = step_y;
        moved_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      track_q     <= 1'b0;
      duty_x_q    <= DUTY_WIDTH'(DutyCtrRst);
      duty_y_q    <= DUTY_WIDTH'(DutyCtrRst);
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        track_q  <= track_d;
        duty_x_q <= duty_x_d;
        duty_y_q <= duty_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_dx_q  <= duty_x_d;
      out_dy_q  <= duty_y_d;
      out_run_q <= track_d;
      out_ont_q <= on_target_d;
      out_mov_q <= moved_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.duty_x    = out_dx_q;
  assign out_o.duty_y    = out_dy_q;
  assign out_o.running   = out_run_q;
  assign out_o.on_target = out_ont_q;
  assign out_o.moved     = out_mov_q;

  // A result that reaches the target has stopped tracking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ont_q |-> !out_run_q)
    else $error("on_target result still shows tracking running");

  // A result either hits the target or moves, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_ont_q && out_mov_q))
    else $error("result reports both on_target and moved");

  // A stepped duty never ends below the minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mov_q |-> (out_dx_q >= duty_min) && (out_dy_q >= duty_min))
    else $error("stepped duty below duty_min");

  // The result register mirrors the servo state it was written with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q |=> out_valid_q && (out_dx_q == duty_x_q) &&
                              (out_dy_q == duty_y_q) && (out_run_q == track_q))
    else $error("result register out of step with servo state");

endmodule
